FILE: hw/rtl/ovl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared sizes, operation and status codes, and the command and status
// bundles between the list controller and the list datapath.
// ----------------------------------------------------------------------------
package ovl_pkg;

    localparam int CAPACITY      = 16;
    localparam int VALUE_W       = 32;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W         = CNT_W + 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic    load;
        logic    append;
        logic    scan_start;
        logic    scan;
        logic    advance;
        logic    shift_step;
        logic    dec_count;
        logic    resp_load;
        t_status resp_code;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                full;
        logic                empty;
        logic                match;
        logic                scan_last;
        logic                shift_last;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/ovl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovl_datapath
// Entry memory, count, scan pointer, operand and result registers of the
// ordered value list. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module ovl_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [ovl_pkg::ACTION_W-1:0]      i_action,
    input  wire logic [ovl_pkg::VALUE_W-1:0]       i_value,
    input  wire ovl_pkg::t_dp_cmd                  i_cmd,
    output ovl_pkg::t_dp_stat                      o_stat,
    output logic [ovl_pkg::STATUS_W-1:0]           o_status,
    output logic [ovl_pkg::ENTRY_COUNT_W-1:0]      o_entry_count
);

    logic [ovl_pkg::VALUE_W-1:0]  r_mem [ovl_pkg::CAPACITY];
    logic [ovl_pkg::ACTION_W-1:0] r_action;
    logic [ovl_pkg::VALUE_W-1:0]  r_value;
    logic [ovl_pkg::VALUE_W-1:0]  r_rd_data;
    logic [ovl_pkg::IDX_W-1:0]    r_idx;
    logic [ovl_pkg::CNT_W-1:0]    r_count;
    logic [ovl_pkg::STATUS_W-1:0] r_status;

    logic [ovl_pkg::SUM_W-1:0]    idx_p1;
    logic [ovl_pkg::SUM_W-1:0]    idx_p2;
    logic [ovl_pkg::SUM_W-1:0]    count_ext;
    logic                         wr_en;
    logic [ovl_pkg::IDX_W-1:0]    wr_addr;
    logic [ovl_pkg::VALUE_W-1:0]  wr_data;
    logic                         rd_en;
    logic [ovl_pkg::IDX_W-1:0]    rd_addr;
    logic [ovl_pkg::CNT_W+ovl_pkg::ENTRY_COUNT_W-1:0] count_wide;

    assign idx_p1    = ovl_pkg::SUM_W'(r_idx) + ovl_pkg::SUM_W'(1);
    assign idx_p2    = ovl_pkg::SUM_W'(r_idx) + ovl_pkg::SUM_W'(2);
    assign count_ext = ovl_pkg::SUM_W'(r_count);

    always_comb begin
        wr_en   = i_cmd.append | i_cmd.shift_step;
        wr_addr = i_cmd.append ? r_count[ovl_pkg::IDX_W-1:0] : r_idx;
        wr_data = i_cmd.append ? r_value : r_rd_data;
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.scan_start) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (i_cmd.shift_step) begin
            rd_en   = (idx_p2 < count_ext);
            rd_addr = idx_p2[ovl_pkg::IDX_W-1:0];
        end else if (i_cmd.scan) begin
            rd_en   = (idx_p1 < count_ext);
            rd_addr = idx_p1[ovl_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.advance || i_cmd.shift_step) begin
            r_idx <= idx_p1[ovl_pkg::IDX_W-1:0];
        end
        if (i_cmd.resp_load) begin
            r_status <= i_cmd.resp_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_count <= r_count + ovl_pkg::CNT_W'(1);
        end else if (i_cmd.dec_count) begin
            r_count <= r_count - ovl_pkg::CNT_W'(1);
        end
    end

    assign count_wide = {{ovl_pkg::ENTRY_COUNT_W{1'b0}}, r_count};

    always_comb begin
        o_stat.action     = r_action;
        o_stat.full       = (r_count == ovl_pkg::CNT_W'(ovl_pkg::CAPACITY));
        o_stat.empty      = (r_count == '0);
        o_stat.match      = (r_rd_data == r_value);
        o_stat.scan_last  = (idx_p1 == count_ext);
        o_stat.shift_last = (idx_p2 == count_ext);
    end

    assign o_status      = r_status;
    assign o_entry_count = count_wide[ovl_pkg::ENTRY_COUNT_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/ovl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovl_ctrl
// Sequencer of the ordered value list: takes one request, steps the datapath
// through append, scan and compaction, and holds the result until taken.
// ----------------------------------------------------------------------------
module ovl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire ovl_pkg::t_dp_stat i_stat,
    output ovl_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.resp_code = ovl_pkg::ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.action)
                    ovl_pkg::ACT_APPEND: begin
                        o_cmd.resp_load = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.resp_code = ovl_pkg::ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                        n_state = S_RESP;
                    end
                    ovl_pkg::ACT_REMOVE, ovl_pkg::ACT_SEARCH: begin
                        if (i_stat.empty) begin
                            o_cmd.resp_load = 1'b1;
                            o_cmd.resp_code = ovl_pkg::ST_NOT_FOUND;
                            n_state         = S_RESP;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.resp_load = 1'b1;
                        n_state         = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.match) begin
                    if (i_stat.action == ovl_pkg::ACT_SEARCH) begin
                        o_cmd.resp_load = 1'b1;
                        n_state         = S_RESP;
                    end else if (i_stat.scan_last) begin
                        o_cmd.dec_count = 1'b1;
                        o_cmd.resp_load = 1'b1;
                        n_state         = S_RESP;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (i_stat.scan_last) begin
                    o_cmd.resp_load = 1'b1;
                    o_cmd.resp_code = ovl_pkg::ST_NOT_FOUND;
                    n_state         = S_RESP;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_last) begin
                    o_cmd.dec_count = 1'b1;
                    o_cmd.resp_load = 1'b1;
                    n_state         = S_RESP;
                end
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_valid = (n_state == S_RESP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule
`default_nettype wire

FILE: hw/rtl/ordered_value_list_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_value_list_top
// Ordered list of up to CAPACITY signed 32-bit values with append, remove
// first match and search requests, each answered by a status and a count.
// ----------------------------------------------------------------------------
// One request is handled at a time. An append, a no-op code, or a remove or
// search on an empty list goes from the execute state straight to the
// result state, where result valid is raised. A search or remove walks the
// stored entries one per cycle through the single read port of the entry
// memory; a remove then shifts each later entry down one place per cycle,
// overlapping the read of the next entry with the write of the current one.
// The next request is taken in the cycle after the result is accepted. The
// list is empty after reset; no clearing pass.
// ----------------------------------------------------------------------------
module ordered_value_list_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [ovl_pkg::ACTION_W-1:0]         i_action,
    input  wire logic signed [ovl_pkg::VALUE_W-1:0]   i_value,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [ovl_pkg::STATUS_W-1:0]              o_status,
    output logic [ovl_pkg::ENTRY_COUNT_W-1:0]         o_entry_count
);

    ovl_pkg::t_dp_cmd  dp_cmd;
    ovl_pkg::t_dp_stat dp_stat;

    ovl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    ovl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule
`default_nettype wire

FILE: tb/tb_ordered_value_list_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_value_list_top
// Drives append, remove-first-match, search and no-op requests into the
// ordered value list and checks each status and count against a shadow list
// kept in the bench. A short directed pass covers the empty, full, duplicate
// and extreme-value cases. Random phases follow, using small value pools so
// removes and searches hit. The sender idles in bursts and the receiver
// stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_ordered_value_list_top;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLDOFF_AT   = 300;
    localparam int HOLDOFF_LEN  = 300;
    localparam int PHASES       = 7;
    localparam int PHASE_REQS   = 147;
    localparam int MAX_PRINTS   = 50;

    localparam logic [ovl_pkg::ACTION_W-1:0] ACT_NOP = 2'd3;

    typedef struct {
        logic [ovl_pkg::ACTION_W-1:0] action;
        logic [ovl_pkg::VALUE_W-1:0]  value;
        bit                           wait_idle;
    } t_list_req;

    typedef struct packed {
        ovl_pkg::t_status                  status;
        logic [ovl_pkg::ENTRY_COUNT_W-1:0] entry_count;
    } t_list_result;

    logic                                i_clk    = 1'b0;
    logic                                i_rst_n  = 1'b0;
    logic                                i_valid  = 1'b0;
    logic [ovl_pkg::ACTION_W-1:0]        i_action = '0;
    logic signed [ovl_pkg::VALUE_W-1:0]  i_value  = '0;
    logic                                i_ready  = 1'b0;
    logic                                o_ready;
    logic                                o_valid;
    logic [ovl_pkg::STATUS_W-1:0]        o_status;
    logic [ovl_pkg::ENTRY_COUNT_W-1:0]   o_entry_count;

    t_list_req                   pending_reqs[$];
    t_list_result                due_results[$];
    logic [ovl_pkg::VALUE_W-1:0] shadow_list[$];

    int reqs_sent    = 0;
    int reqs_taken   = 0;
    int results_seen = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;

    ordered_value_list_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic t_list_result apply_list_op(
        input logic [ovl_pkg::ACTION_W-1:0] act,
        input logic [ovl_pkg::VALUE_W-1:0]  val
    );
        int           hit;
        t_list_result res;
        hit = -1;
        for (int k = 0; k < shadow_list.size(); k++) begin
            if (hit < 0 && shadow_list[k] == val) begin
                hit = k;
            end
        end
        res.status = ovl_pkg::ST_DONE;
        case (act)
            ovl_pkg::ACT_APPEND: begin
                if (shadow_list.size() >= ovl_pkg::CAPACITY) begin
                    res.status = ovl_pkg::ST_FULL;
                end else begin
                    shadow_list.push_back(val);
                end
            end
            ovl_pkg::ACT_REMOVE: begin
                if (hit < 0) begin
                    res.status = ovl_pkg::ST_NOT_FOUND;
                end else begin
                    shadow_list.delete(hit);
                end
            end
            ovl_pkg::ACT_SEARCH: begin
                if (hit < 0) begin
                    res.status = ovl_pkg::ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        res.entry_count = ovl_pkg::ENTRY_COUNT_W'(shadow_list.size());
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) begin
            $display("MISMATCH result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        end
    endtask

    task automatic add_req(input logic [ovl_pkg::ACTION_W-1:0] act,
                           input logic [ovl_pkg::VALUE_W-1:0] val,
                           input bit hold_for_idle);
        t_list_req req;
        req.action    = act;
        req.value     = val;
        req.wait_idle = hold_for_idle;
        pending_reqs.push_back(req);
    endtask

    // Driver: one request outstanding at a time, bursts separated by gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin : req_driver
        t_list_req nxt;
        logic      send;
        send = 1'b0;
        if (i_rst_n && reqs_sent == reqs_taken) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                if (!pending_reqs[0].wait_idle || due_results.size() == 0) begin
                    nxt = pending_reqs.pop_front();
                    send = 1'b1;
                    reqs_sent++;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            i_valid <= send;
            if (send) begin
                i_action <= nxt.action;
                i_value  <= nxt.value;
            end
        end
    end

    // Receiver: the stall mode is redrawn after each random run; one long hold-off.
    int               holdoff_left = 0;
    bit               holdoff_done = 1'b0;
    int               stall_mode   = 0;
    int               pat_left     = 0;
    logic [7:0]       pat_word     = 8'hFF;

    always @(negedge i_clk) begin : result_receiver
        logic rdy;
        rdy = 1'b1;
        if (i_rst_n) begin
            if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                rdy = 1'b0;
            end else begin
                if (pat_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    pat_left   = $urandom_range(16, 96);
                    pat_word   = 8'($urandom) | 8'h01;
                end
                pat_left--;
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 7) != 0);
                    default: rdy = pat_word[pat_left % 8];
                endcase
            end
            i_ready <= rdy;
        end
    end

    // Monitor: predict on request acceptance, check on result acceptance.
    always @(posedge i_clk) begin : result_monitor
        t_list_result want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && o_ready) begin
                reqs_taken++;
                due_results.push_back(apply_list_op(i_action, i_value));
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch("result with none due, status", o_status, -1);
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch("status", o_status, want.status);
                    end
                    if (o_entry_count !== want.entry_count) begin
                        report_mismatch("entry_count", o_entry_count, want.entry_count);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [ovl_pkg::VALUE_W-1:0]  pool [0:23];
        logic [ovl_pkg::ACTION_W-1:0] act;
        logic [ovl_pkg::VALUE_W-1:0]  val;
        int                           pool_n;
        int                           add_pct;
        int                           rem_pct;
        int                           roll;

        // Directed: empty list, no-op, fill to capacity, full, duplicates.
        add_req(ovl_pkg::ACT_REMOVE, 32'h0000_0007, 1'b0);
        add_req(ovl_pkg::ACT_SEARCH, 32'h8000_0000, 1'b0);
        add_req(ACT_NOP,             32'hFFFF_FFFF, 1'b0);
        add_req(ovl_pkg::ACT_APPEND, 32'h8000_0000, 1'b0);
        add_req(ovl_pkg::ACT_APPEND, 32'h7FFF_FFFF, 1'b0);
        add_req(ovl_pkg::ACT_APPEND, 32'h0000_0000, 1'b0);
        add_req(ovl_pkg::ACT_APPEND, 32'hFFFF_FFFF, 1'b0);
        add_req(ovl_pkg::ACT_APPEND, 32'h5555_5555, 1'b0);
        add_req(ovl_pkg::ACT_APPEND, 32'hAAAA_AAAA, 1'b0);
        add_req(ovl_pkg::ACT_APPEND, 32'h0000_0007, 1'b0);
        add_req(ovl_pkg::ACT_APPEND, 32'h0000_0007, 1'b0);
        for (int k = 0; k < ovl_pkg::CAPACITY - 8; k++) begin
            add_req(ovl_pkg::ACT_APPEND, $urandom, 1'b0);
        end
        add_req(ovl_pkg::ACT_APPEND, 32'h1234_5678, 1'b0);
        add_req(ovl_pkg::ACT_SEARCH, 32'h7FFF_FFFF, 1'b0);
        add_req(ovl_pkg::ACT_SEARCH, 32'h1234_5678, 1'b0);
        add_req(ovl_pkg::ACT_REMOVE, 32'h0000_0007, 1'b0);
        add_req(ovl_pkg::ACT_REMOVE, 32'h1234_5678, 1'b0);
        add_req(ACT_NOP,             32'h0000_0000, 1'b0);

        // Random phases alternate between filling and draining the list.
        for (int ph = 0; ph < PHASES; ph++) begin
            pool_n  = $urandom_range(3, 24);
            add_pct = (ph % 2 == 0) ? 65 : 30;
            rem_pct = (ph % 2 == 0) ? 20 : 45;
            for (int k = 0; k < pool_n; k++) begin
                case ($urandom_range(0, 5))
                    0: pool[k] = 32'h8000_0000;
                    1: pool[k] = 32'h7FFF_FFFF;
                    default: pool[k] = $urandom;
                endcase
            end
            for (int k = 0; k < PHASE_REQS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    act = ACT_NOP;
                end else if (roll < add_pct) begin
                    act = ovl_pkg::ACT_APPEND;
                end else if (roll < add_pct + rem_pct) begin
                    act = ovl_pkg::ACT_REMOVE;
                end else begin
                    act = ovl_pkg::ACT_SEARCH;
                end
                val = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
                add_req(act, val, k == 0);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || reqs_sent != reqs_taken || due_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ovl_pkg.sv
hw/rtl/ovl_datapath.sv
hw/rtl/ovl_ctrl.sv
hw/rtl/ordered_value_list_top.sv
tb/tb_ordered_value_list_top.sv
